>>> rtl/hpt_pkg.sv
package hpt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int FIELD_W       = 32;
  // three full products plus the translation term, before scaling back
  localparam int SUM_W         = 67;
  localparam int CMD_DEPTH     = 2;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_DIR   = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_POINT,
    KIND_DIR
  } kind_e;

  typedef struct packed {
    logic [1:0]                opcode;
    logic [1:0]                entry_row;
    logic [1:0]                entry_col;
    logic signed [FIELD_W-1:0] entry_value;
    logic signed [FIELD_W-1:0] vec_x;
    logic signed [FIELD_W-1:0] vec_y;
    logic signed [FIELD_W-1:0] vec_z;
  } in_word_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic                      w_zero_error;
    logic                      saturated;
  } out_word_t;

  typedef struct packed {
    kind_e                     kind;
    logic [3:0]                addr;
    logic signed [FIELD_W-1:0] val;
    logic signed [FIELD_W-1:0] vx;
    logic signed [FIELD_W-1:0] vy;
    logic signed [FIELD_W-1:0] vz;
  } cmd_t;

endpackage

>>> rtl/hpt_front.sv
module hpt_front #(
  parameter int WORD_BITS = hpt_pkg::WORD_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  hpt_pkg::in_word_t in_data_i,
  output logic             cmd_push_o,
  input  logic             cmd_full_i,
  output hpt_pkg::cmd_t    cmd_o
);

  localparam int VAL_BITS = (WORD_BITS < hpt_pkg::FIELD_W) ? WORD_BITS : hpt_pkg::FIELD_W;
  localparam int SH       = hpt_pkg::FIELD_W - VAL_BITS;

  logic          valid_q, valid_d;
  hpt_pkg::cmd_t cmd_q, cmd_d;
  logic          keep;
  logic          accept;

  function automatic logic signed [hpt_pkg::FIELD_W-1:0] sext_val(
    input logic signed [hpt_pkg::FIELD_W-1:0] x
  );
    logic signed [hpt_pkg::FIELD_W-1:0] t;
    t = x <<< SH;
    return t >>> SH;
  endfunction

  assign full       = valid_q && cmd_full_i;
  assign accept     = push && !full;
  assign cmd_push_o = valid_q && !cmd_full_i;
  assign cmd_o      = cmd_q;

  always_comb begin
    cmd_d.addr = {in_data_i.entry_row, in_data_i.entry_col};
    cmd_d.val  = sext_val(in_data_i.entry_value);
    cmd_d.vx   = sext_val(in_data_i.vec_x);
    cmd_d.vy   = sext_val(in_data_i.vec_y);
    cmd_d.vz   = sext_val(in_data_i.vec_z);
    keep       = 1'b1;
    case (in_data_i.opcode)
      hpt_pkg::OP_LOAD:  cmd_d.kind = hpt_pkg::KIND_LOAD;
      hpt_pkg::OP_POINT: cmd_d.kind = hpt_pkg::KIND_POINT;
      hpt_pkg::OP_DIR:   cmd_d.kind = hpt_pkg::KIND_DIR;
      default: begin
        // unused opcode: dropped here
        cmd_d.kind = hpt_pkg::KIND_LOAD;
        keep       = 1'b0;
      end
    endcase
  end

  assign valid_d = (accept && keep) || (valid_q && cmd_full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

>>> rtl/hpt_cmd_fifo.sv
module hpt_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hpt_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output hpt_pkg::cmd_t rdata_o
);

  localparam int PW = $clog2(hpt_pkg::CMD_DEPTH);
  localparam int CW = $clog2(hpt_pkg::CMD_DEPTH + 1);

  hpt_pkg::cmd_t   mem_q [hpt_pkg::CMD_DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(hpt_pkg::CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PW'(1);
      if (do_pop)  rd_q <= rd_q + PW'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/hpt_div.sv
module hpt_div #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = hpt_pkg::WORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [hpt_pkg::SUM_W-1:0]  num_i,
  input  logic signed [hpt_pkg::SUM_W-1:0]  den_i,
  output logic                              done_o,
  output logic signed [hpt_pkg::FIELD_W-1:0] quo_o,
  output logic                              sat_o
);

  localparam int SW       = hpt_pkg::SUM_W;
  localparam int VAL_BITS = (WORD_BITS < hpt_pkg::FIELD_W) ? WORD_BITS : hpt_pkg::FIELD_W;
  localparam int NW       = SW + FRAC_BITS;
  localparam int QB       = VAL_BITS + 1;
  localparam int REM_W    = SW + 1;
  localparam int CNT_W    = $clog2(QB + 1);
  localparam logic [QB-1:0] QMAX_POS = QB'((64'd1 << (VAL_BITS - 1)) - 64'd1);
  localparam logic [QB-1:0] QMAX_NEG = QB'(64'd1 << (VAL_BITS - 1));
  localparam logic signed [hpt_pkg::FIELD_W-1:0] VMAX =
    hpt_pkg::FIELD_W'((64'd1 << (VAL_BITS - 1)) - 64'd1);
  localparam logic signed [hpt_pkg::FIELD_W-1:0] VMIN = -VMAX - 1;

  logic             busy_q, big_q, neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [REM_W-1:0] rem_q, rem_sh, rem_d;
  logic [SW-1:0]    dabs_q;
  logic [QB-1:0]    lo_q, q_q;
  logic [SW-1:0]    nabs, dabs;
  logic [NW-1:0]    nsh, hi;
  logic             ge, ovf;

  assign nabs = num_i[SW-1] ? SW'(-num_i) : SW'(num_i);
  assign dabs = den_i[SW-1] ? SW'(-den_i) : SW'(den_i);
  assign nsh  = NW'(nabs) << FRAC_BITS;
  assign hi   = nsh >> QB;

  assign rem_sh = {rem_q[REM_W-2:0], lo_q[QB-1]};
  assign ge     = rem_sh >= REM_W'(dabs_q);
  assign rem_d  = ge ? rem_sh - REM_W'(dabs_q) : rem_sh;

  assign done_o = busy_q && (big_q || cnt_q == '0);
  assign ovf    = big_q || (neg_q ? (q_q > QMAX_NEG) : (q_q > QMAX_POS));
  assign sat_o  = ovf;

  always_comb begin
    if (ovf) begin
      quo_o = neg_q ? VMIN : VMAX;
    end else if (neg_q) begin
      quo_o = -hpt_pkg::FIELD_W'(q_q);
    end else begin
      quo_o = hpt_pkg::FIELD_W'(q_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(QB);
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // quotient needs more than QB bits: saturate without iterating
      big_q  <= hi >= NW'(dabs);
      neg_q  <= num_i[SW-1] != den_i[SW-1];
      dabs_q <= dabs;
      rem_q  <= hi[REM_W-1:0];
      lo_q   <= nsh[QB-1:0];
      q_q    <= '0;
    end else if (busy_q && !done_o) begin
      rem_q <= rem_d;
      lo_q  <= lo_q << 1;
      q_q   <= {q_q[QB-2:0], ge};
    end
  end

endmodule

>>> rtl/hpt_back.sv
module hpt_back #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = hpt_pkg::WORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_empty_i,
  input  hpt_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               empty,
  input  logic               pop,
  output hpt_pkg::out_word_t out_data_o
);

  localparam int FW       = hpt_pkg::FIELD_W;
  localparam int SW       = hpt_pkg::SUM_W;
  localparam int ACC_W    = 2 * FW + 2;
  localparam int VAL_BITS = (WORD_BITS < FW) ? WORD_BITS : FW;
  localparam logic signed [FW-1:0] VMAX = FW'((64'd1 << (VAL_BITS - 1)) - 64'd1);
  localparam logic signed [FW-1:0] VMIN = -VMAX - 1;
  localparam logic signed [FW-1:0] ONE  =
    (FRAC_BITS >= VAL_BITS - 1) ? VMAX : FW'(64'd1 << FRAC_BITS);
  localparam logic signed [SW-1:0] SMAX = SW'(VMAX);
  localparam logic signed [SW-1:0] SMIN = SW'(VMIN);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_COL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]              state_q;
  logic signed [FW-1:0]    mat_q [16];
  logic [1:0]              col_q, step_q;
  logic                    point_q, sat_q, wz_q;
  logic signed [FW-1:0]    vx_q, vy_q, vz_q;
  logic signed [FW-1:0]    res_q [3];
  logic signed [2*FW-1:0]  prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [SW-1:0]    w_q;
  logic                    out_valid_q;
  hpt_pkg::out_word_t      out_q;

  logic [3:0]              rd_addr;
  logic signed [FW-1:0]    mat_rd, v_sel, trans;
  logic signed [SW-1:0]    col_sum;
  logic                    div_start, div_done, div_sat;
  logic signed [FW-1:0]    div_quo;

  assign rd_addr = (state_q == S_COL) ? {2'd3, col_q} : {step_q, col_q};
  assign mat_rd  = mat_q[rd_addr];
  assign trans   = point_q ? mat_rd : '0;
  // the exact sum of the products is floored once, then the translation is added
  assign col_sum = SW'(acc_q >>> FRAC_BITS) + SW'(trans);

  always_comb begin
    case (step_q)
      2'd0:    v_sel = vx_q;
      2'd1:    v_sel = vy_q;
      default: v_sel = vz_q;
    endcase
  end

  assign cmd_pop_o = (state_q == S_IDLE) && !cmd_empty_i;
  assign div_start = (state_q == S_COL) && point_q && (col_q != 2'd3);
  assign empty     = !out_valid_q;
  assign out_data_o = out_q;

  hpt_div #(
    .FRAC_BITS(FRAC_BITS),
    .WORD_BITS(WORD_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (col_sum),
    .den_i  (w_q),
    .done_o (div_done),
    .quo_o  (div_quo),
    .sat_o  (div_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        mat_q[i] <= (i % 5 == 0) ? ONE : '0;
      end
    end else begin
      if (out_valid_q && pop) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_pop_o) begin
            if (cmd_i.kind == hpt_pkg::KIND_LOAD) begin
              mat_q[cmd_i.addr] <= cmd_i.val;
            end else begin
              state_q <= S_MAC;
            end
          end
        end
        S_MAC: begin
          if (step_q == 2'd3) state_q <= S_COL;
        end
        S_COL: begin
          if (point_q && col_q == 2'd3) begin
            state_q <= (col_sum == '0) ? S_OUT : S_MAC;
          end else if (point_q) begin
            state_q <= S_DIV;
          end else if (col_q == 2'd2) begin
            state_q <= S_OUT;
          end else begin
            state_q <= S_MAC;
          end
        end
        S_DIV: begin
          if (div_done) state_q <= (col_q == 2'd2) ? S_OUT : S_MAC;
        end
        S_OUT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        vx_q    <= cmd_i.vx;
        vy_q    <= cmd_i.vy;
        vz_q    <= cmd_i.vz;
        point_q <= (cmd_i.kind == hpt_pkg::KIND_POINT);
        // a point starts with the w column
        col_q   <= (cmd_i.kind == hpt_pkg::KIND_POINT) ? 2'd3 : 2'd0;
        step_q  <= 2'd0;
        sat_q   <= 1'b0;
        wz_q    <= 1'b0;
      end
      S_MAC: begin
        if (step_q != 2'd3) prod_q <= v_sel * mat_rd;
        if (step_q == 2'd1) begin
          acc_q <= ACC_W'(prod_q);
        end else if (step_q != 2'd0) begin
          acc_q <= acc_q + ACC_W'(prod_q);
        end
        step_q <= step_q + 2'd1;
      end
      S_COL: begin
        if (point_q && col_q == 2'd3) begin
          w_q   <= col_sum;
          col_q <= 2'd0;
          if (col_sum == '0) begin
            wz_q     <= 1'b1;
            res_q[0] <= '0;
            res_q[1] <= '0;
            res_q[2] <= '0;
          end
        end else if (!point_q) begin
          if (col_sum > SMAX) begin
            res_q[col_q] <= VMAX;
            sat_q        <= 1'b1;
          end else if (col_sum < SMIN) begin
            res_q[col_q] <= VMIN;
            sat_q        <= 1'b1;
          end else begin
            res_q[col_q] <= col_sum[FW-1:0];
          end
          col_q <= col_q + 2'd1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_q[col_q] <= div_quo;
          sat_q        <= sat_q | div_sat;
          col_q        <= col_q + 2'd1;
        end
      end
      S_OUT: begin
        if (!out_valid_q) begin
          out_q.out_x        <= res_q[0];
          out_q.out_y        <= res_q[1];
          out_q.out_z        <= res_q[2];
          out_q.w_zero_error <= wz_q;
          out_q.saturated    <= sat_q;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/homogeneous_point_transform_top.sv
// channel   handshake         payload
// input     push / full       in_data_i  (hpt_pkg::in_word_t)
// result    empty / pop       out_data_o (hpt_pkg::out_word_t)
//
// A load passes through the front register and the command queue. A direction
// runs three columns of three products on one shared 32x32 multiplier. A point
// first forms the w column, then, unless w is zero, divides each of its three
// columns by w on the bit-serial divider (one quotient bit per cycle).
// Reset loads the identity matrix at once. The two-entry command queue lets
// the front keep taking words while the back works or its result waits.
module homogeneous_point_transform_top #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = hpt_pkg::WORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  hpt_pkg::in_word_t  in_data_i,
  output logic               empty,
  input  logic               pop,
  output hpt_pkg::out_word_t out_data_o
);

  logic          cmd_push, cmd_full, cmd_pop, cmd_empty;
  hpt_pkg::cmd_t cmd_wr, cmd_rd;

  hpt_front #(
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_data_i (in_data_i),
    .cmd_push_o(cmd_push),
    .cmd_full_i(cmd_full),
    .cmd_o     (cmd_wr)
  );

  hpt_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_wr),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .empty_o(cmd_empty),
    .rdata_o(cmd_rd)
  );

  hpt_back #(
    .FRAC_BITS(FRAC_BITS),
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_rd),
    .cmd_pop_o  (cmd_pop),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_full && cmd_empty))
    else $error("command queue both full and empty");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !cmd_full)
    else $error("front pushed into full queue");

  a_pop_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("back popped empty queue");

  a_wzero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.w_zero_error) |->
      (!out_data_o.saturated && out_data_o.out_x == '0 &&
       out_data_o.out_y == '0 && out_data_o.out_z == '0))
    else $error("zero-w result not cleared");

endmodule
